// ----- design/rcbm_pkg.sv -----
// rcbm_pkg: word types, blend mode codes and per-lane pipeline record
// for the rgb channel blend block; no dependencies
package rcbm_pkg;

    localparam logic [4:0] MODE_NORMAL     = 5'd0;
    localparam logic [4:0] MODE_LIGHTEN    = 5'd1;
    localparam logic [4:0] MODE_DARKEN     = 5'd2;
    localparam logic [4:0] MODE_MULTIPLY   = 5'd3;
    localparam logic [4:0] MODE_AVERAGE    = 5'd4;
    localparam logic [4:0] MODE_ADD        = 5'd5;
    localparam logic [4:0] MODE_SUBTRACT   = 5'd6;
    localparam logic [4:0] MODE_DIFFERENCE = 5'd7;
    localparam logic [4:0] MODE_NEGATION   = 5'd8;
    localparam logic [4:0] MODE_SCREEN     = 5'd9;
    localparam logic [4:0] MODE_EXCLUSION  = 5'd10;
    localparam logic [4:0] MODE_OVERLAY    = 5'd11;
    localparam logic [4:0] MODE_SOFT_LIGHT = 5'd12;
    localparam logic [4:0] MODE_HARD_LIGHT = 5'd13;
    localparam logic [4:0] MODE_DODGE      = 5'd14;
    localparam logic [4:0] MODE_BURN       = 5'd15;
    localparam logic [4:0] MODE_LIN_DODGE  = 5'd16;
    localparam logic [4:0] MODE_LIN_BURN   = 5'd17;
    localparam logic [4:0] MODE_LIN_LIGHT  = 5'd18;
    localparam logic [4:0] MODE_VIVID      = 5'd19;
    localparam logic [4:0] MODE_PIN_LIGHT  = 5'd20;
    localparam logic [4:0] MODE_HARD_MIX   = 5'd21;
    localparam logic [4:0] MODE_REFLECT    = 5'd22;
    localparam logic [4:0] MODE_GLOW       = 5'd23;
    localparam logic [4:0] MODE_PHOENIX    = 5'd24;

    localparam logic [4:0] MODE_RESET      = MODE_DARKEN;

    localparam logic [0:0] REG_BLEND_MODE  = 1'b0;

    localparam logic [7:0] MAXV = 8'd255;
    localparam logic [7:0] HALF = 8'd128;
    localparam logic [7:0] QTR  = 8'd64;

    typedef struct packed {
        logic [7:0] a_chan0;
        logic [7:0] a_chan1;
        logic [7:0] a_chan2;
        logic [7:0] b_chan0;
        logic [7:0] b_chan1;
        logic [7:0] b_chan2;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_chan0;
        logic [7:0] out_chan1;
        logic [7:0] out_chan2;
    } t_out_word;

    // one channel's record as it moves down the pipeline
    typedef struct packed {
        logic [7:0]  s;      // result of the plain modes
        logic [8:0]  sum;    // a + b
        logic        up;     // upper branch: 255 - quotient
        logic        dbl;    // numerator is twice the product
        logic        ceil;   // round the /255 upward
        logic        usep;   // divider dividend is the product
        logic        burn;   // burn style divider result
        logic [7:0]  d;      // divisor
        logic [7:0]  da;     // dividend high byte when shifted
        logic [7:0]  x;
        logic [7:0]  y;
        logic [15:0] p;
        logic [15:0] n;
        logic [16:0] m;
        logic        sat;
        logic [7:0]  rem;
        logic [7:0]  q;
        logic [8:0]  qe;
    } t_lane;

endpackage

// ----- design/rgb_channel_blend_modes.sv -----
// rgb_channel_blend_modes: top level, per-pixel separable blend of two rgb8 layers
// depends on rcbm_pkg (word types, mode codes, lane record)

// Takes one pixel pair per clock and returns the blended pixel at the output
// register; a new word is accepted every cycle while no finished word waits or
// the output is ready. The pipeline holds operand select, one 8x8 multiply,
// numerator build, two stages of a 4-bit-per-stage restoring divider
// (shared by dodge, burn, vivid light, hard mix, reflect and glow) that also run
// the divide-by-255 estimate and correction, and a final select into the output
// register. A stall freezes the whole pipeline. blend_mode resets to darken;
// codes 25 to 31 pass the first layer through unchanged.
module rgb_channel_blend_modes (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  rcbm_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output rcbm_pkg::t_out_word  o_out_word,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int NST = 5;

    logic [4:0]      r_mode;
    logic [NST-1:0]  r_vld;
    logic [4:0]      r_md  [NST];
    rcbm_pkg::t_lane r_st  [NST][3];
    rcbm_pkg::t_lane n_st0 [3];
    rcbm_pkg::t_lane n_st  [1:NST-1][3];
    logic            r_out_vld;
    rcbm_pkg::t_out_word r_out;
    rcbm_pkg::t_out_word n_out;
    logic            en;
    logic [7:0]      in_a [3];
    logic [7:0]      in_b [3];

    // ---- configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == rcbm_pkg::REG_BLEND_MODE) ? {27'd0, r_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= rcbm_pkg::MODE_RESET;
        end else if (psel && penable && pwrite && paddr[2] == rcbm_pkg::REG_BLEND_MODE) begin
            r_mode <= pwdata[4:0];
        end
    end

    // ---- global pipeline advance, held only while a finished word waits
    assign en          = !r_out_vld || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

    assign in_a[0] = i_in_word.a_chan0;
    assign in_a[1] = i_in_word.a_chan1;
    assign in_a[2] = i_in_word.a_chan2;
    assign in_b[0] = i_in_word.b_chan0;
    assign in_b[1] = i_in_word.b_chan1;
    assign in_b[2] = i_in_word.b_chan2;

    // ---- stage 0: operand select and plain modes
    always_comb begin
        logic [7:0] a, b, c, b2, df, mn, mx;
        logic [8:0] sm, t9;
        for (int ch = 0; ch < 3; ch++) begin
            a  = in_a[ch];
            b  = in_b[ch];
            c  = {1'b0, a[7:1]} + rcbm_pkg::QTR;
            b2 = {b[6:0], 1'b0};
            df = (a > b) ? a - b : b - a;
            mn = (a < b) ? a : b;
            mx = (a > b) ? a : b;
            sm = {1'b0, a} + {1'b0, b};
            t9 = '0;
            n_st0[ch]      = '0;
            n_st0[ch].sum  = sm;
            n_st0[ch].x    = a;
            n_st0[ch].y    = b;
            n_st0[ch].d    = ~b;
            n_st0[ch].da   = a;
            n_st0[ch].s    = a;
            case (r_mode)
                rcbm_pkg::MODE_LIGHTEN:    n_st0[ch].s = mx;
                rcbm_pkg::MODE_DARKEN:     n_st0[ch].s = mn;
                rcbm_pkg::MODE_AVERAGE:    n_st0[ch].s = sm[8:1];
                rcbm_pkg::MODE_ADD, rcbm_pkg::MODE_LIN_DODGE:
                    n_st0[ch].s = sm[8] ? rcbm_pkg::MAXV : sm[7:0];
                rcbm_pkg::MODE_SUBTRACT, rcbm_pkg::MODE_LIN_BURN:
                    n_st0[ch].s = (sm < 9'd255) ? 8'd0 : 8'(sm - 9'd255);
                rcbm_pkg::MODE_DIFFERENCE: n_st0[ch].s = df;
                rcbm_pkg::MODE_NEGATION:
                    n_st0[ch].s = (sm > 9'd255) ? 8'(10'd510 - {1'b0, sm}) : sm[7:0];
                rcbm_pkg::MODE_PHOENIX:    n_st0[ch].s = rcbm_pkg::MAXV - df;
                rcbm_pkg::MODE_LIN_LIGHT: begin
                    if (b < rcbm_pkg::HALF) begin
                        t9 = sm + {1'b0, b};
                        n_st0[ch].s = (t9 < 9'd255) ? 8'd0 : 8'(t9 - 9'd255);
                    end else begin
                        t9 = {1'b0, a} + {1'b0, b2};
                        n_st0[ch].s = t9[8] ? rcbm_pkg::MAXV : t9[7:0];
                    end
                end
                rcbm_pkg::MODE_PIN_LIGHT: begin
                    if (b < rcbm_pkg::HALF) begin
                        n_st0[ch].s = (a < b2) ? a : b2;
                    end else begin
                        n_st0[ch].s = (a > b2) ? a : b2;
                    end
                end
                rcbm_pkg::MODE_SCREEN: begin
                    n_st0[ch].x = ~a;
                    n_st0[ch].y = ~b;
                end
                rcbm_pkg::MODE_EXCLUSION:  n_st0[ch].dbl = 1'b1;
                rcbm_pkg::MODE_OVERLAY: begin
                    n_st0[ch].dbl = 1'b1;
                    if (b[7]) begin
                        n_st0[ch].x  = ~a;
                        n_st0[ch].y  = ~b;
                        n_st0[ch].up = 1'b1;
                    end
                end
                rcbm_pkg::MODE_HARD_LIGHT: begin
                    n_st0[ch].dbl = 1'b1;
                    if (a[7]) begin
                        n_st0[ch].x  = ~a;
                        n_st0[ch].y  = ~b;
                        n_st0[ch].up = 1'b1;
                    end
                end
                rcbm_pkg::MODE_SOFT_LIGHT: begin
                    n_st0[ch].dbl = 1'b1;
                    n_st0[ch].x   = c;
                    if (b[7]) begin
                        n_st0[ch].x    = ~c;
                        n_st0[ch].y    = ~b;
                        n_st0[ch].up   = 1'b1;
                        n_st0[ch].ceil = 1'b1;
                    end
                end
                rcbm_pkg::MODE_BURN: begin
                    n_st0[ch].d    = b;
                    n_st0[ch].da   = ~a;
                    n_st0[ch].burn = 1'b1;
                end
                rcbm_pkg::MODE_VIVID, rcbm_pkg::MODE_HARD_MIX: begin
                    if (!b[7]) begin
                        n_st0[ch].d    = b2;
                        n_st0[ch].da   = ~a;
                        n_st0[ch].burn = 1'b1;
                    end else begin
                        n_st0[ch].d    = ~b2;
                    end
                end
                rcbm_pkg::MODE_REFLECT: begin
                    n_st0[ch].x    = a;
                    n_st0[ch].y    = a;
                    n_st0[ch].usep = 1'b1;
                end
                rcbm_pkg::MODE_GLOW: begin
                    n_st0[ch].x    = b;
                    n_st0[ch].y    = b;
                    n_st0[ch].usep = 1'b1;
                    n_st0[ch].d    = ~a;
                end
                default: ;
            endcase
        end
    end

    // ---- stages 1 to 4: multiply, numerator, divider and /255
    always_comb begin
        logic [8:0]  t;
        logic [25:0] e;
        logic [17:0] r;
        for (int ch = 0; ch < 3; ch++) begin
            // multiply
            n_st[1][ch]   = r_st[0][ch];
            n_st[1][ch].p = r_st[0][ch].x * r_st[0][ch].y;

            // numerators and divider setup
            n_st[2][ch]   = r_st[1][ch];
            n_st[2][ch].n = r_st[1][ch].usep ? r_st[1][ch].p : {r_st[1][ch].da, 8'h00};
            n_st[2][ch].m = (r_st[1][ch].dbl ? {r_st[1][ch].p, 1'b0} : {1'b0, r_st[1][ch].p})
                          + (r_st[1][ch].ceil ? 17'd254 : 17'd0);
            n_st[2][ch].sat = (n_st[2][ch].n[15:8] >= r_st[1][ch].d);
            n_st[2][ch].rem = n_st[2][ch].n[15:8];
            n_st[2][ch].q   = '0;

            // divider bits 7..4, reciprocal estimate of m/255
            n_st[3][ch] = r_st[2][ch];
            for (int i = 7; i >= 4; i--) begin
                t = {n_st[3][ch].rem, n_st[3][ch].n[i]};
                if (t >= {1'b0, n_st[3][ch].d}) begin
                    n_st[3][ch].rem  = 8'(t - {1'b0, n_st[3][ch].d});
                    n_st[3][ch].q[i] = 1'b1;
                end else begin
                    n_st[3][ch].rem = t[7:0];
                end
            end
            e = {9'd0, r_st[2][ch].m} + {1'b0, r_st[2][ch].m, 8'd0};
            n_st[3][ch].qe = e[24:16];

            // divider bits 3..0, one-step correction of the estimate
            n_st[4][ch] = r_st[3][ch];
            for (int i = 3; i >= 0; i--) begin
                t = {n_st[4][ch].rem, n_st[4][ch].n[i]};
                if (t >= {1'b0, n_st[4][ch].d}) begin
                    n_st[4][ch].rem  = 8'(t - {1'b0, n_st[4][ch].d});
                    n_st[4][ch].q[i] = 1'b1;
                end else begin
                    n_st[4][ch].rem = t[7:0];
                end
            end
            r = {1'b0, r_st[3][ch].m} + {9'd0, r_st[3][ch].qe}
              - {1'b0, r_st[3][ch].qe, 8'd0};
            if (r >= 18'd255) begin
                n_st[4][ch].qe = r_st[3][ch].qe + 9'd1;
            end
        end
    end

    // ---- final select
    always_comb begin
        logic [7:0] res [3];
        logic [7:0] dv, q8;
        rcbm_pkg::t_lane l;
        for (int ch = 0; ch < 3; ch++) begin
            l  = r_st[4][ch];
            q8 = l.qe[7:0];
            if (l.d == 8'd0) begin
                dv = l.burn ? 8'd0 : rcbm_pkg::MAXV;
            end else if (l.burn) begin
                dv = (l.sat || l.q == rcbm_pkg::MAXV) ? 8'd0 : rcbm_pkg::MAXV - l.q;
            end else begin
                dv = l.sat ? rcbm_pkg::MAXV : l.q;
            end
            case (r_md[4])
                rcbm_pkg::MODE_MULTIPLY:   res[ch] = q8;
                rcbm_pkg::MODE_SCREEN:     res[ch] = rcbm_pkg::MAXV - l.p[15:8];
                rcbm_pkg::MODE_EXCLUSION:  res[ch] = 8'(l.sum - l.qe);
                rcbm_pkg::MODE_OVERLAY, rcbm_pkg::MODE_SOFT_LIGHT, rcbm_pkg::MODE_HARD_LIGHT:
                    res[ch] = l.up ? rcbm_pkg::MAXV - q8 : q8;
                rcbm_pkg::MODE_DODGE, rcbm_pkg::MODE_BURN, rcbm_pkg::MODE_VIVID,
                rcbm_pkg::MODE_REFLECT, rcbm_pkg::MODE_GLOW:
                    res[ch] = dv;
                rcbm_pkg::MODE_HARD_MIX:
                    res[ch] = (dv < rcbm_pkg::HALF) ? 8'd0 : rcbm_pkg::MAXV;
                default:                   res[ch] = l.s;
            endcase
        end
        n_out.out_chan0 = res[0];
        n_out.out_chan1 = res[1];
        n_out.out_chan2 = res[2];
    end

    // ---- pipeline registers, valid bits travel with the words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld     <= {r_vld[NST-2:0], i_in_valid};
            r_out_vld <= r_vld[NST-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_md[0] <= r_mode;
            for (int k = 1; k < NST; k++) begin
                r_md[k] <= r_md[k-1];
            end
            for (int ch = 0; ch < 3; ch++) begin
                r_st[0][ch] <= n_st0[ch];
            end
            for (int k = 1; k < NST; k++) begin
                for (int ch = 0; ch < 3; ch++) begin
                    r_st[k][ch] <= n_st[k][ch];
                end
            end
            r_out <= n_out;
        end
    end

    // ---- assertions
    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("input ready does not follow output stall");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld) && $stable(r_out_vld))
        else $error("pipeline moved during a stall");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en |=> r_vld[0] == $past(i_in_valid))
        else $error("accepted word not captured in first stage");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en |=> r_out_vld == $past(r_vld[NST-1]))
        else $error("last stage word lost on its way out");

endmodule
